// File: rtl/sfr_pkg.sv
// Shared constants, register indexes and the burst descriptor type of the find-and-replace unit.
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int BYTE_W    = 8;
   localparam int MAX_PAT   = 8;                       // longest find or replace pattern
   localparam int PAT_W     = MAX_PAT * BYTE_W;        // width of a pattern register
   localparam int LEN_W     = $clog2(MAX_PAT);         // index of a byte inside a burst
   localparam int CNT_W     = $clog2(MAX_PAT + 1);     // holds 0..MAX_PAT
   localparam int COUNT_W   = 16;                      // replacement counter width
   localparam int CSR_IDX_W = 3;
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FIND_PATTERN    = 3'd0,
      REG_FIND_LENGTH     = 3'd1,
      REG_REPLACE_PATTERN = 3'd2,
      REG_REPLACE_LENGTH  = 3'd3,
      REG_MAX_REPLACE     = 3'd4,
      REG_UNLIMITED       = 3'd5
   } reg_index_type;

   // One burst of result bytes caused by a single input transaction.
   typedef struct packed {
      logic [MAX_PAT-1:0][BYTE_W-1:0] data;
      logic [LEN_W-1:0]               len_m1;   // number of bytes minus one
      logic                           empty;    // end marker without a byte
      logic                           last;     // burst closes the string
   } job_type;

   // Status of the queue seen by both its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: rtl/substring_find_replace_unit.sv
// Top level of the streaming find-and-replace unit.
`timescale 1ns / 1ps

// Streaming find-and-replace: a string enters one byte per transaction with tlast on
// its final byte, and leaves with the leftmost non-overlapping occurrences of the find
// pattern (1 to 8 bytes) replaced by the replacement (0 to 8 bytes). Up to find
// length minus one bytes wait inside the unit until they can be decided, and they are
// flushed at string end. Result tuser is 1 when tdata carries a byte; a string whose
// output would be empty ends with one transaction that has tuser 0 and tlast 1. The
// unit takes one byte per cycle as long as each byte causes at most one result and the
// receiver is ready; the output serializer sends one result per cycle while the receiver
// is ready, and the two-entry burst queue stalls input once it is full. An accepted byte's
// first result passes through the burst queue and then the output register. Configuration
// writes are always ready and are to be made only while no result is outstanding;
// writing the find length discards the pending bytes.
module substring_find_replace_unit (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sfr_pkg::PAT_W-1:0]     csr_wdata,
   // input byte stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] char_byte
   input  logic                          req_tlast,   // string_end
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] out_byte
   output logic                          rsp_tuser,   // [0] byte_valid
   output logic                          rsp_tlast    // out_end
);
   import sfr_pkg::*;

   job_type      push_job, head_job;
   q_status_type q_status;
   logic         q_push, q_pop;

   assign csr_ready = 1'b1;

   sfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .in_ready  (req_tready),
      .q_status  (q_status),
      .push      (q_push),
      .job       (push_job)
   );

   sfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   sfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_status   (q_status),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // The queue is never written while full nor read while empty.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("burst queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("burst queue read while empty");

   // A result without a byte only ever closes a string.
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("empty result transaction that does not end the string");

   // A burst that ends a string carries either bytes or the end marker, never both.
   a_empty_burst_single: assert property (@(posedge clock) disable iff (reset)
      (q_push && push_job.empty) |-> (push_job.last && (push_job.len_m1 == '0)))
      else $error("malformed empty burst");
`endif

endmodule

// File: rtl/sfr_front.sv
// Front end: configuration registers, pending window, pattern match and burst classification.
`timescale 1ns / 1ps

module sfr_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sfr_pkg::PAT_W-1:0]             csr_wdata,
   input  logic                                  in_valid,
   input  logic [sfr_pkg::BYTE_W-1:0]            in_byte,
   input  logic                                  in_last,
   output logic                                  in_ready,
   input  sfr_pkg::q_status_type                 q_status,
   output logic                                  push,
   output sfr_pkg::job_type                      job
);
   import sfr_pkg::*;

   logic [PAT_W-1:0]   find_pat_ff;
   logic [3:0]         find_len_ff;
   logic [PAT_W-1:0]   repl_pat_ff;
   logic [3:0]         repl_len_ff;
   logic [COUNT_W-1:0] max_repl_ff;
   logic               unlimited_ff;

   logic [MAX_PAT-1:0][BYTE_W-1:0] win_ff, win_in, win_app;
   logic [CNT_W-1:0]   win_cnt_ff, win_cnt_in, win_cnt_app;
   logic [COUNT_W-1:0] repl_cnt_ff, repl_cnt_in;

   logic [CNT_W-1:0]   fl, rl, burst_len;
   logic [MAX_PAT-1:0] byte_ok;
   logic               accept, full_win, allowed, hit;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      // Lengths outside the supported range are clamped.
      fl = find_len_ff;
      if (find_len_ff == '0) begin
         fl = CNT_W'(1);
      end else if (find_len_ff > 4'(MAX_PAT)) begin
         fl = CNT_W'(MAX_PAT);
      end
      rl = (repl_len_ff > 4'(MAX_PAT)) ? CNT_W'(MAX_PAT) : repl_len_ff;

      // Window with the incoming byte appended after the pending ones.
      for (int i = 0; i < MAX_PAT; i++) begin
         win_app[i] = (win_cnt_ff == CNT_W'(i)) ? in_byte : win_ff[i];
      end
      win_cnt_app = (win_cnt_ff < CNT_W'(MAX_PAT)) ? win_cnt_ff + 1'b1 : win_cnt_ff;
      full_win    = (win_cnt_app >= fl);

      allowed = unlimited_ff ||
                ((repl_cnt_ff < max_repl_ff) && (repl_cnt_ff != '1));
      for (int i = 0; i < MAX_PAT; i++) begin
         byte_ok[i] = (CNT_W'(i) >= fl) || (win_app[i] == find_pat_ff[i*BYTE_W +: BYTE_W]);
      end
      hit = full_win && allowed && (&byte_ok);

      // A miss releases the oldest byte; at string end the whole window drains.
      win_in      = win_app;
      win_cnt_in  = win_cnt_app;
      repl_cnt_in = repl_cnt_ff;
      job.data    = win_app;
      burst_len   = '0;
      if (hit) begin
         job.data   = repl_pat_ff;
         burst_len  = rl;
         win_cnt_in = '0;
         if (repl_cnt_ff != '1) begin
            repl_cnt_in = repl_cnt_ff + 1'b1;
         end
      end else if (full_win) begin
         for (int i = 0; i < MAX_PAT - 1; i++) begin
            win_in[i] = win_app[i+1];
         end
         win_cnt_in = win_cnt_app - 1'b1;
         burst_len  = in_last ? win_cnt_app : CNT_W'(1);
      end else begin
         burst_len  = in_last ? win_cnt_app : '0;
      end
      if (in_last) begin
         win_cnt_in  = '0;
         repl_cnt_in = '0;
      end

      job.empty  = (burst_len == '0);
      job.last   = in_last;
      job.len_m1 = job.empty ? '0 : LEN_W'(burst_len - 1'b1);
      push       = accept && (!job.empty || in_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         find_pat_ff  <= '0;
         find_len_ff  <= 4'd1;
         repl_pat_ff  <= '0;
         repl_len_ff  <= '0;
         max_repl_ff  <= '0;
         unlimited_ff <= 1'b1;
         win_cnt_ff   <= '0;
         repl_cnt_ff  <= '0;
      end else begin
         // Writing the find length discards the pending bytes.
         if (csr_valid && (csr_index == REG_FIND_LENGTH)) begin
            win_cnt_ff <= '0;
         end else if (accept) begin
            win_cnt_ff <= win_cnt_in;
         end
         if (accept) begin
            repl_cnt_ff <= repl_cnt_in;
         end
         if (csr_valid) begin
            unique case (csr_index)
               REG_FIND_PATTERN:    find_pat_ff  <= csr_wdata;
               REG_FIND_LENGTH:     find_len_ff  <= csr_wdata[3:0];
               REG_REPLACE_PATTERN: repl_pat_ff  <= csr_wdata;
               REG_REPLACE_LENGTH:  repl_len_ff  <= csr_wdata[3:0];
               REG_MAX_REPLACE:     max_repl_ff  <= csr_wdata[COUNT_W-1:0];
               REG_UNLIMITED:       unlimited_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

// File: rtl/sfr_queue.sv
// Two-entry queue of result bursts between the front end and the output serializer.
`timescale 1ns / 1ps

module sfr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sfr_pkg::job_type      push_job,
   input  logic                  pop,
   output sfr_pkg::job_type      head_job,
   output sfr_pkg::q_status_type status
);
   import sfr_pkg::*;

   job_type              entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign head_job     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/sfr_back.sv
// Back end: serializes each queued burst into result transactions through an output register.
`timescale 1ns / 1ps

module sfr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sfr_pkg::job_type              head_job,
   input  sfr_pkg::q_status_type         q_status,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sfr_pkg::BYTE_W-1:0]    rsp_tdata,
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);
   import sfr_pkg::*;

   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic              valid_ff;
   logic [BYTE_W-1:0] data_ff;
   logic              user_ff, last_ff;
   logic              load, at_end;

   assign load   = (!valid_ff || rsp_tready) && !q_status.empty;
   assign at_end = (idx_ff == head_job.len_m1);
   assign pop    = load && at_end;
   assign idx_in = at_end ? '0 : idx_ff + 1'b1;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= idx_in;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= head_job.empty ? '0 : head_job.data[idx_ff];
         user_ff <= !head_job.empty;
         last_ff <= head_job.last && at_end;
      end
   end

endmodule

// File: verif/substring_find_replace_unit_tb.sv
// Self-checking testbench for the streaming find-and-replace unit.
`timescale 1ns / 1ps

module substring_find_replace_unit_tb;
   import sfr_pkg::*;

   // Index 7 decodes to no register, so a write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam logic [COUNT_W-1:0]   COUNT_TOP  = '1;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       last;
   } result_type;

   typedef enum logic [1:0] {ROW_CONFIG, ROW_BYTE, ROW_FILL} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [PAT_W-1:0]     wdata;
      logic [7:0]           char_b;
      logic                 str_end;
      bit                   typed;
      result_type           want;
      int                   fill_len;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [PAT_W-1:0]     csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;

   substring_find_replace_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Shadow copy of the configuration and the matching window.
   logic [PAT_W-1:0]   cfg_find_pat = '0;
   logic [3:0]         cfg_find_len = 4'd1;
   logic [PAT_W-1:0]   cfg_repl_pat = '0;
   logic [3:0]         cfg_repl_len = 4'd0;
   logic [COUNT_W-1:0] cfg_max_repl = '0;
   logic               cfg_unlimited = 1'b1;
   logic [7:0]         win_bytes [MAX_PAT];
   int                 win_count = 0;
   logic [COUNT_W-1:0] rep_count = '0;

   result_type step_results [$];
   result_type pending [$];
   row_type    stim_table [$];

   int errors = 0;
   int items_sent = 0;
   int strings_sent = 0;
   int results_seen = 0;
   int settings_used = 0;
   int burst_left = 0;
   bit steady = 1'b0;

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= 40) begin
         $display("MISMATCH at %0t ns: %s", $time, what);
      end
   endtask

   function automatic void drop_window(input int k);
      int j;
      if (k >= win_count) begin
         win_count = 0;
      end else begin
         for (j = 0; j < win_count - k; j++) begin
            win_bytes[j] = win_bytes[j + k];
         end
         win_count -= k;
      end
   endfunction

   function automatic void push_result(input logic [7:0] b, input logic has_b);
      result_type r;
      r.data     = b;
      r.has_byte = has_b;
      r.last     = 1'b0;
      step_results.insert(step_results.size(), r);
   endfunction

   // Works out the results that one accepted byte causes.
   function automatic void rewrite_step(input logic [7:0] in_byte, input logic in_end);
      int  fl;
      int  rl;
      int  k;
      bit  hit;
      step_results.delete();
      fl = (cfg_find_len == 4'd0) ? 1 : ((cfg_find_len > 4'd8) ? 8 : int'(cfg_find_len));
      if (fl > MAX_PAT) fl = MAX_PAT;
      rl = (cfg_repl_len > 4'd8) ? 8 : int'(cfg_repl_len);
      if (win_count < MAX_PAT) begin
         win_bytes[win_count] = in_byte;
         win_count++;
      end
      if (win_count >= fl) begin
         hit = cfg_unlimited || (rep_count < cfg_max_repl && rep_count != COUNT_TOP);
         for (k = 0; k < fl && hit; k++) begin
            if (win_bytes[k] != cfg_find_pat[8*k +: 8]) hit = 1'b0;
         end
         if (hit) begin
            for (k = 0; k < rl; k++) push_result(cfg_repl_pat[8*k +: 8], 1'b1);
            if (rep_count != COUNT_TOP) rep_count++;
            drop_window(fl);
         end else begin
            push_result(win_bytes[0], 1'b1);
            drop_window(1);
         end
      end
      if (in_end) begin
         for (k = 0; k < win_count; k++) push_result(win_bytes[k], 1'b1);
         win_count = 0;
         rep_count = '0;
         if (step_results.size() == 0) push_result(8'h00, 1'b0);
         step_results[step_results.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic void apply_config(input logic [CSR_IDX_W-1:0] idx,
                                        input logic [PAT_W-1:0] value);
      case (idx)
         REG_FIND_PATTERN:    cfg_find_pat = value;
         REG_FIND_LENGTH: begin
            cfg_find_len = value[3:0];
            win_count = 0;
         end
         REG_REPLACE_PATTERN: cfg_repl_pat = value;
         REG_REPLACE_LENGTH:  cfg_repl_len = value[3:0];
         REG_MAX_REPLACE:     cfg_max_repl = value[COUNT_W-1:0];
         REG_UNLIMITED:       cfg_unlimited = value[0];
         default: ;
      endcase
   endfunction

   // csr_valid stays high between back-to-back writes; csr_release drops it.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [PAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      apply_config(idx, value);
   endtask

   task automatic csr_release();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Holds the input off until every expected result is back, and then lets
   // a byte with no result settle inside the unit.
   task automatic pause_sender();
      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic str_end,
                            input bit typed, input result_type want);
      int gap;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= str_end;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      items_sent++;
      if (str_end) strings_sent++;
      rewrite_step(b, str_end);
      if (typed) begin
         pending.insert(pending.size(), want);
      end else begin
         foreach (step_results[i]) pending.insert(pending.size(), step_results[i]);
      end
   endtask

   task automatic program_setting(input logic [PAT_W-1:0] fpat, input logic [3:0] flen,
                                  input logic [PAT_W-1:0] rpat, input logic [3:0] rlen,
                                  input logic [COUNT_W-1:0] maxr, input logic unlim);
      pause_sender();
      csr_write(REG_FIND_PATTERN, fpat);
      // Upper bits of the narrow registers are noise that the unit must drop.
      csr_write(REG_FIND_LENGTH, {$urandom, $urandom} & ~64'hF | 64'(flen));
      csr_write(REG_REPLACE_PATTERN, rpat);
      csr_write(REG_REPLACE_LENGTH, {$urandom, $urandom} & ~64'hF | 64'(rlen));
      csr_write(REG_MAX_REPLACE, 64'(maxr));
      csr_write(REG_UNLIMITED, 64'(unlim));
      if ($urandom_range(0, 1)) csr_write(REG_UNUSED, {$urandom, $urandom});
      csr_release();
      settings_used++;
   endtask

   function automatic void add_cfg(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [PAT_W-1:0] value);
      row_type r;
      r = '{kind: ROW_CONFIG, default: '0};
      r.index = idx;
      r.wdata = value;
      stim_table.insert(stim_table.size(), r);
   endfunction

   function automatic void add_byte(input logic [7:0] b, input logic str_end,
                                    input bit typed, input result_type want);
      row_type r;
      r = '{kind: ROW_BYTE, default: '0};
      r.char_b  = b;
      r.str_end = str_end;
      r.typed   = typed;
      r.want    = want;
      stim_table.insert(stim_table.size(), r);
   endfunction

   // Receiver stalls: a new mode each time the phase counter wraps, one of them never stalls.
   logic [5:0] stall_phase = '0;
   logic [1:0] stall_mode = '0;

   always @(posedge clock) begin
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_phase % 5 != 0);
      endcase
   end

   result_type got_r;
   result_type want_r;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got_r = '{data: rsp_tdata, has_byte: rsp_tuser, last: rsp_tlast};
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result data=%02h user=%0b last=%0b",
                                      got_r.data, got_r.has_byte, got_r.last));
         end else begin
            want_r = pending.pop_front();
            if (got_r.data !== want_r.data)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         got_r.data, want_r.data));
            if (got_r.has_byte !== want_r.has_byte)
               report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                         got_r.has_byte, want_r.has_byte));
            if (got_r.last !== want_r.last)
               report_mismatch($sformatf("out_end %0b, expected %0b",
                                         got_r.last, want_r.last));
         end
      end
   end

   initial begin
      int            r;
      int            n;
      int            ph;
      int            phase_items;
      int            len;
      int            k;
      int            choice;
      int            flen_eff;
      logic [7:0]    alpha [3];
      logic [7:0]    str_q [$];
      logic [PAT_W-1:0] fpat;
      logic [3:0]    flen;
      logic [3:0]    rlen;
      logic [COUNT_W-1:0] maxr;
      logic [7:0]    b;
      result_type    none;

      none = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: a one-byte zero pattern deleted by an empty replacement.
      add_byte(8'h00, 1'b1, 1'b1, '{data: 8'h00, has_byte: 1'b0, last: 1'b1});
      add_byte(8'hFF, 1'b1, 1'b1, '{data: 8'hFF, has_byte: 1'b1, last: 1'b1});
      // Two-byte pattern, replace length above eight acts as eight.
      add_cfg(REG_FIND_PATTERN, 64'h6261);
      add_cfg(REG_FIND_LENGTH, 64'd2);
      add_cfg(REG_REPLACE_PATTERN, 64'h8877_6655_4433_2211);
      add_cfg(REG_REPLACE_LENGTH, 64'd15);
      add_byte(8'h61, 1'b0, 1'b0, none);
      add_byte(8'h61, 1'b0, 1'b0, none);
      add_byte(8'h62, 1'b0, 1'b0, none);
      add_byte(8'h78, 1'b1, 1'b0, none);
      // Find length zero acts as one; a limit of one replacement per string.
      add_cfg(REG_FIND_PATTERN, 64'h7A);
      add_cfg(REG_FIND_LENGTH, 64'd0);
      add_cfg(REG_REPLACE_LENGTH, 64'd0);
      add_cfg(REG_MAX_REPLACE, 64'd1);
      add_cfg(REG_UNLIMITED, 64'd0);
      add_byte(8'h7A, 1'b0, 1'b0, none);
      add_byte(8'h7A, 1'b1, 1'b0, none);
      // Longest pattern of all ones replaced by eight zero bytes.
      add_cfg(REG_FIND_PATTERN, '1);
      add_cfg(REG_FIND_LENGTH, 64'd8);
      add_cfg(REG_REPLACE_PATTERN, 64'd0);
      add_cfg(REG_REPLACE_LENGTH, 64'd8);
      add_cfg(REG_UNLIMITED, 64'd1);
      for (k = 0; k < 8; k++) add_byte(8'hFF, k == 7, 1'b0, none);
      // Rewriting the find length mid-string throws away the pending bytes.
      add_cfg(REG_FIND_PATTERN, 64'h636261);
      add_cfg(REG_FIND_LENGTH, 64'd3);
      add_byte(8'h61, 1'b0, 1'b0, none);
      add_byte(8'h62, 1'b0, 1'b0, none);
      add_cfg(REG_FIND_LENGTH, 64'd3);
      add_byte(8'h63, 1'b1, 1'b0, none);
      // A write to an undecoded index leaves every register alone.
      add_cfg(REG_UNUSED, '1);
      add_byte(8'h61, 1'b1, 1'b0, none);
      // A limit of zero blocks every replacement.
      add_cfg(REG_FIND_PATTERN, 64'h71);
      add_cfg(REG_FIND_LENGTH, 64'd1);
      add_cfg(REG_REPLACE_LENGTH, 64'd2);
      add_cfg(REG_MAX_REPLACE, 64'd0);
      add_cfg(REG_UNLIMITED, 64'd0);
      add_byte(8'h71, 1'b1, 1'b1, '{data: 8'h71, has_byte: 1'b1, last: 1'b1});
      // A steady run of the pattern: deletions stop once the limit of five is reached.
      add_cfg(REG_FIND_PATTERN, 64'h61);
      add_cfg(REG_REPLACE_LENGTH, 64'd0);
      add_cfg(REG_MAX_REPLACE, 64'd5);
      begin
         row_type fr;
         fr = '{kind: ROW_FILL, default: '0};
         fr.char_b   = 8'h61;
         fr.fill_len = 12;
         stim_table.insert(stim_table.size(), fr);
      end

      for (r = 0; r < stim_table.size(); r++) begin
         case (stim_table[r].kind)
            ROW_CONFIG: begin
               if (r == 0 || stim_table[r-1].kind != ROW_CONFIG) pause_sender();
               csr_write(stim_table[r].index, stim_table[r].wdata);
               if (r + 1 == stim_table.size() || stim_table[r+1].kind != ROW_CONFIG) begin
                  csr_release();
                  settings_used++;
               end
            end
            ROW_BYTE: begin
               send_byte(stim_table[r].char_b, stim_table[r].str_end,
                         stim_table[r].typed, stim_table[r].want);
            end
            default: begin
               steady = 1'b1;
               for (n = 0; n < stim_table[r].fill_len; n++)
                  send_byte(stim_table[r].char_b, n == stim_table[r].fill_len - 1,
                            1'b0, none);
               steady = 1'b0;
            end
         endcase
      end

      // Random phases: each starts from an idle unit with a new setting.
      for (ph = 0; ph < 8; ph++) begin
         for (k = 0; k < 3; k++) alpha[k] = 8'($urandom);
         fpat = {$urandom, $urandom};
         case (ph)
            0: begin flen = 4'd1;  rlen = 4'd0;  maxr = '0;    end
            1: begin flen = 4'd15; rlen = 4'd8;  maxr = '1;    end
            2: begin flen = 4'd2;  rlen = 4'd1;  maxr = 16'd1; end
            default: begin
               flen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 4));
               rlen = 4'($urandom_range(0, 15));
               choice = $urandom_range(0, 3);
               maxr = (choice == 0) ? '0 : (choice == 1) ? 16'($urandom_range(1, 3))
                    : (choice == 2) ? '1 : 16'($urandom);
            end
         endcase
         flen_eff = (flen == 0) ? 1 : (flen > 8) ? 8 : int'(flen);
         for (k = 0; k < flen_eff; k++) fpat[8*k +: 8] = alpha[$urandom_range(0, 2)];
         program_setting(fpat, flen, {$urandom, $urandom}, rlen, maxr,
                         (ph == 0) ? 1'b1 : (ph < 3) ? 1'b0 : 1'($urandom_range(0, 1)));
         steady = (ph % 4 == 3);
         phase_items = 0;
         while (phase_items < 12) begin
            str_q.delete();
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 12);
            while (str_q.size() < len) begin
               choice = $urandom_range(0, 9);
               if (choice < 4) begin
                  // A copy of the pattern, now and then with one byte broken.
                  n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, flen_eff - 1) : -1;
                  for (k = 0; k < flen_eff; k++)
                     str_q.insert(str_q.size(), (k == n) ? 8'($urandom) : fpat[8*k +: 8]);
               end else if (choice < 8) begin
                  str_q.insert(str_q.size(), alpha[$urandom_range(0, 2)]);
               end else begin
                  str_q.insert(str_q.size(), 8'($urandom));
               end
            end
            for (k = 0; k < str_q.size(); k++) begin
               b = str_q[k];
               send_byte(b, k == str_q.size() - 1, 1'b0, none);
               phase_items++;
            end
         end
         steady = 1'b0;
      end

      req_tvalid <= 1'b0;
      n = 0;
      while (pending.size() != 0 && n < 50000) begin
         @(posedge clock);
         n++;
      end
      repeat (10) @(posedge clock);
      if (pending.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", pending.size()));

      $display("Run covered %0d strings, %0d input bytes and %0d results", strings_sent,
               items_sent, results_seen);
      $display("over %0d register settings, with stalls on both streams", settings_used);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
